// ===== rtl/srpc_pkg.sv =====
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared widths, types and codes of the servo packet ramp controller.
// ----------------------------------------------------------------------------
package srpc_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int STEP_COUNT_BITS = 10;

  localparam int NUM_CH    = 3;
  localparam int ANGLE_W   = 8;
  localparam int POS_W     = FRAC_BITS + ANGLE_W;
  localparam int INC_W     = POS_W + 1;
  localparam int DIV_CNT_W = $clog2(POS_W);
  localparam int RAMP_W    = 10;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  // Bit positions in the result tdata.
  localparam int POWER_BIT  = 48;
  localparam int EVENT_LSB  = 49;
  localparam int MOVING_BIT = 52;
  localparam int PENDING_BIT = 53;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BYTE     = 3'd1,
    EV_PACKET   = 3'd2,
    EV_BAD_TYPE = 3'd3,
    EV_RANGE    = 3'd4
  } event_t;

  typedef logic [NUM_CH-1:0][ANGLE_W-1:0] angle_vec_t;

  typedef struct packed {
    event_t ev;
    logic   packet_ok;
  } parse_res_t;

endpackage

// ===== rtl/srpc_parser.sv =====
// ----------------------------------------------------------------------------
// srpc_parser
// Packet parser: collects type byte and three angles, checks the angle limits.
// ----------------------------------------------------------------------------
module srpc_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_stb,
  input  logic [7:0]           data,
  input  srpc_pkg::angle_vec_t min_angle,
  input  srpc_pkg::angle_vec_t max_angle,
  output srpc_pkg::parse_res_t res,
  output srpc_pkg::angle_vec_t angles
);
  import srpc_pkg::*;

  localparam logic [1:0] BI_TYPE = 2'd0;
  localparam logic [1:0] BI_A    = 2'd1;
  localparam logic [1:0] BI_B    = 2'd2;
  localparam logic [1:0] BI_C    = 2'd3;
  localparam logic [7:0] TYPE_SERVO = 8'd1;

  logic [1:0]         byte_index;
  logic [1:0]         byte_index_next;
  logic [ANGLE_W-1:0] recv [2];
  logic               range_ok;

  always_comb begin
    angles[0] = recv[0];
    angles[1] = recv[1];
    angles[2] = data;
    range_ok = 1'b1;
    for (int i = 0; i < NUM_CH; i++) begin
      if (angles[i] < min_angle[i] || angles[i] > max_angle[i]) range_ok = 1'b0;
    end
  end

  always_comb begin
    res.ev = EV_NONE;
    res.packet_ok = 1'b0;
    byte_index_next = byte_index;
    if (byte_stb) begin
      unique case (byte_index)
        BI_TYPE: begin
          if (data == TYPE_SERVO) begin
            byte_index_next = BI_A;
            res.ev = EV_BYTE;
          end else begin
            res.ev = EV_BAD_TYPE;
          end
        end
        BI_A, BI_B: begin
          byte_index_next = byte_index + 2'd1;
          res.ev = EV_BYTE;
        end
        BI_C: begin
          byte_index_next = BI_TYPE;
          res.packet_ok = range_ok;
          res.ev = range_ok ? EV_PACKET : EV_RANGE;
        end
        default: byte_index_next = BI_TYPE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= BI_TYPE;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  // The first two angles are held; the third arrives with the closing byte.
  always_ff @(posedge clk) begin
    if (byte_stb && (byte_index == BI_A || byte_index == BI_B)) begin
      recv[byte_index[1]] <= data;
    end
  end

endmodule

// ===== rtl/srpc_divider.sv =====
// ----------------------------------------------------------------------------
// srpc_divider
// Bit-serial restoring divider, signed dividend, truncates toward zero.
// ----------------------------------------------------------------------------
module srpc_divider (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic signed [srpc_pkg::INC_W-1:0]         dividend,
  input  logic [srpc_pkg::STEP_COUNT_BITS-1:0]      divisor,
  output logic                                      done,
  output logic signed [srpc_pkg::INC_W-1:0]         quotient
);
  import srpc_pkg::*;

  logic                       busy;
  logic [DIV_CNT_W-1:0]       cnt;
  logic                       neg;
  logic [POS_W-1:0]           mag;
  logic [POS_W-1:0]           mag_next;
  logic [STEP_COUNT_BITS-1:0] rem;
  logic [STEP_COUNT_BITS-1:0] rem_next;
  logic [STEP_COUNT_BITS-1:0] dvs;
  logic [STEP_COUNT_BITS:0]   trial;
  logic [STEP_COUNT_BITS:0]   trial_sub;
  logic                       ge;
  logic signed [INC_W-1:0]    abs_in;

  always_comb begin
    trial = {rem, mag[POS_W-1]};
    ge = trial >= {1'b0, dvs};
    trial_sub = trial - {1'b0, dvs};
    rem_next = ge ? trial_sub[STEP_COUNT_BITS-1:0] : trial[STEP_COUNT_BITS-1:0];
    mag_next = {mag[POS_W-2:0], ge};
    abs_in = dividend[INC_W-1] ? -dividend : dividend;
    quotient = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(POS_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[INC_W-1];
        mag  <= abs_in[POS_W-1:0];
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        mag <= mag_next;
        rem <= rem_next;
        if (cnt == DIV_CNT_W'(POS_W - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/servo_packet_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// servo_packet_ramp_controller
// Parses servo packets from a byte stream and ramps three servo positions.
// ----------------------------------------------------------------------------
// Each input item is a received byte (tuser 0) or a step tick (tuser 1), and
// each gives exactly one result item. A byte passes through the execute and
// emit states; a tick that steps a running move through execute, step and
// emit, and an idle tick through execute and emit. The tick that starts a move
// first computes the three per-channel increments on one bit-serial divider,
// one channel after another, and then steps. One item is worked on at a time;
// the next item is accepted while the last result waits in the output
// register. Limit and ramp registers are written over the APB port.
// ----------------------------------------------------------------------------
module servo_packet_ramp_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // data_byte[7:0]
  input  logic [srpc_pkg::IN_TDATA_W-1:0]        s_tdata,
  // command[0]
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pos_a[7:0], pos_b[15:8], pos_c[23:16], mirror_a[31:24], mirror_b[39:32],
  // mirror_c[47:40], power_on[48], event_res[51:49], moving[52], pending[53]
  output logic [srpc_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [srpc_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [srpc_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [srpc_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import srpc_pkg::*;

  localparam logic [2:0] REG_RAMP_STEPS = 3'd0;
  localparam logic [2:0] REG_MIN_A      = 3'd1;
  localparam logic [2:0] REG_MAX_A      = 3'd2;
  localparam logic [2:0] REG_MIN_B      = 3'd3;
  localparam logic [2:0] REG_MAX_B      = 3'd4;
  localparam logic [2:0] REG_MIN_C      = 3'd5;
  localparam logic [2:0] REG_MAX_C      = 3'd6;

  localparam logic [ANGLE_W-1:0] RESET_POS  [NUM_CH] = '{8'd100, 8'd80, 8'd45};
  localparam logic [ANGLE_W-1:0] MIRROR_OFS [NUM_CH] = '{8'd227, 8'd214, 8'd179};
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
  localparam logic [1:0]         LAST_CH    = 2'(NUM_CH - 1);
  localparam logic [31:0]        STEP_MAX   = (32'd1 << STEP_COUNT_BITS) - 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV_GO, ST_DIV_WAIT, ST_STEP, ST_EMIT
  } state_t;

  // Configuration registers.
  logic [RAMP_W-1:0] ramp_steps;
  angle_vec_t        min_angle;
  angle_vec_t        max_angle;
  logic [2:0]        reg_index;
  logic              cfg_write;

  // Block state.
  state_t                     state;
  logic                       cmd_r;
  logic [7:0]                 data_r;
  logic [ANGLE_W-1:0]         target [NUM_CH];
  logic                       pending_valid;
  logic [POS_W-1:0]           position [NUM_CH];
  logic signed [INC_W-1:0]    increment [NUM_CH];
  logic [STEP_COUNT_BITS-1:0] steps_left;
  logic [STEP_COUNT_BITS-1:0] steps_r;
  logic                       drive_on;
  logic [1:0]                 ch;
  event_t                     ev_r;
  logic                       power_r;

  // Datapath.
  logic                       byte_stb;
  parse_res_t                 parse;
  angle_vec_t                 rx_angles;
  logic                       div_start;
  logic                       div_done;
  logic signed [INC_W-1:0]    div_dividend;
  logic signed [INC_W-1:0]    div_q;
  logic [POS_W-1:0]           stepped [NUM_CH];
  logic signed [POS_W+1:0]    sum [NUM_CH];
  logic [ANGLE_W-1:0]         pos_int [NUM_CH];
  logic [ANGLE_W-1:0]         mir [NUM_CH];
  logic signed [ANGLE_W+1:0]  mir_diff [NUM_CH];
  logic [OUT_TDATA_W-1:0]     result_next;
  logic [31:0]                steps_clip;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_steps   <= RAMP_W'(150);
      min_angle[0] <= 8'd83;
      max_angle[0] <= 8'd124;
      min_angle[1] <= 8'd72;
      max_angle[1] <= 8'd132;
      min_angle[2] <= 8'd0;
      max_angle[2] <= 8'd180;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_RAMP_STEPS: ramp_steps   <= pwdata[RAMP_W-1:0];
        REG_MIN_A:      min_angle[0] <= pwdata[ANGLE_W-1:0];
        REG_MAX_A:      max_angle[0] <= pwdata[ANGLE_W-1:0];
        REG_MIN_B:      min_angle[1] <= pwdata[ANGLE_W-1:0];
        REG_MAX_B:      max_angle[1] <= pwdata[ANGLE_W-1:0];
        REG_MIN_C:      min_angle[2] <= pwdata[ANGLE_W-1:0];
        REG_MAX_C:      max_angle[2] <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_RAMP_STEPS: prdata = APB_DATA_W'(ramp_steps);
      REG_MIN_A:      prdata = APB_DATA_W'(min_angle[0]);
      REG_MAX_A:      prdata = APB_DATA_W'(max_angle[0]);
      REG_MIN_B:      prdata = APB_DATA_W'(min_angle[1]);
      REG_MAX_B:      prdata = APB_DATA_W'(max_angle[1]);
      REG_MIN_C:      prdata = APB_DATA_W'(min_angle[2]);
      REG_MAX_C:      prdata = APB_DATA_W'(max_angle[2]);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Parser and divider
  // --------------------------------------------------------------------------
  assign byte_stb  = (state == ST_EXEC) && !cmd_r;
  assign div_start = (state == ST_DIV_GO);
  assign s_tready  = (state == ST_IDLE);

  srpc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_stb  (byte_stb),
    .data      (data_r),
    .min_angle (min_angle),
    .max_angle (max_angle),
    .res       (parse),
    .angles    (rx_angles)
  );

  assign div_dividend = $signed({1'b0, target[ch], {FRAC_BITS{1'b0}}})
                      - $signed({1'b0, position[ch]});

  srpc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (steps_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // --------------------------------------------------------------------------
  // Step adders, mirrored commands and result packing
  // --------------------------------------------------------------------------
  always_comb begin
    // A ramp length of zero behaves as one step.
    steps_clip = 32'(ramp_steps);
    if (steps_clip == 32'd0) steps_clip = 32'd1;
    if (steps_clip > STEP_MAX) steps_clip = STEP_MAX;

    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = $signed({2'b00, position[i]}) + $signed({increment[i][INC_W-1], increment[i]});
      if (sum[i][POS_W+1]) begin
        stepped[i] = '0;
      end else if (sum[i][POS_W]) begin
        stepped[i] = '1;
      end else begin
        stepped[i] = sum[i][POS_W-1:0];
      end

      pos_int[i]  = position[i][POS_W-1 -: ANGLE_W];
      mir_diff[i] = $signed({2'b00, MIRROR_OFS[i]}) - $signed({2'b00, pos_int[i]});
      if (mir_diff[i] < 0) begin
        mir[i] = '0;
      end else if (mir_diff[i] > $signed({2'b00, ANGLE_MAX})) begin
        mir[i] = ANGLE_MAX;
      end else begin
        mir[i] = mir_diff[i][ANGLE_W-1:0];
      end
    end

    result_next = {2'b00, pending_valid, (steps_left != '0), ev_r, power_r,
                   mir[2], mir[1], mir[0], pos_int[2], pos_int[1], pos_int[0]};
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      pending_valid <= 1'b0;
      steps_left    <= '0;
      drive_on      <= 1'b0;
      ch            <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        position[i]  <= POS_W'(RESET_POS[i]) << FRAC_BITS;
        increment[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != ST_EMIT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r  <= s_tuser;
            data_r <= s_tdata;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!cmd_r) begin
            ev_r    <= parse.ev;
            power_r <= drive_on;
            if (parse.packet_ok) begin
              for (int i = 0; i < NUM_CH; i++) target[i] <= rx_angles[i];
              pending_valid <= 1'b1;
            end
            state <= ST_EMIT;
          end else begin
            ev_r <= EV_NONE;
            if (steps_left == '0 && pending_valid) begin
              steps_r <= steps_clip[STEP_COUNT_BITS-1:0];
              ch      <= '0;
              state   <= ST_DIV_GO;
            end else if (steps_left != '0) begin
              state <= ST_STEP;
            end else begin
              power_r <= 1'b0;
              state   <= ST_EMIT;
            end
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            increment[ch] <= div_q;
            if (ch == LAST_CH) begin
              steps_left    <= steps_r;
              pending_valid <= 1'b0;
              state         <= ST_STEP;
            end else begin
              ch    <= ch + 2'd1;
              state <= ST_DIV_GO;
            end
          end
        end
        ST_STEP: begin
          for (int i = 0; i < NUM_CH; i++) position[i] <= stepped[i];
          steps_left <= steps_left - 1'b1;
          // Drive goes off with the last step of the move; that step's result still reports power on.
          drive_on   <= (steps_left != STEP_COUNT_BITS'(1));
          power_r    <= 1'b1;
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= result_next;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_power_while_moving: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[MOVING_BIT] |-> m_tdata[POWER_BIT])
    else $error("result reports a running move with power off");

  a_drive_tracks_steps: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> drive_on == (steps_left != '0))
    else $error("drive_on disagrees with the remaining step count");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside a move start");

  a_start_takes_packet: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP && $past(state) == ST_DIV_WAIT |-> !pending_valid && steps_left != '0)
    else $error("move start did not consume the pending packet");

endmodule
